[rtl/core/assert_macros.svh]
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/fol_pkg.sv]
package fol_pkg;

    // Default table depth and the cap on dump output.
    localparam int DEPTH_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;

    // Transaction kinds.
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_ACCESS = 2'd1,
        KIND_DUMP   = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  key;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [7:0]  out_key;
        logic [15:0] out_count;
        logic [3:0]  position;
        logic        last;
    } t_result;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [7:0]  key;
        logic [15:0] count;
    } t_entry;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_BUBBLE,
        S_WRITE,
        S_DUMP
    } t_state;

endpackage

[rtl/core/fol_ram.sv]
module fol_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/frequency_ordered_list_unit.sv]
// Frequency-ordered key table. A transaction is taken when start is high and busy is
// low; every result appears for one cycle with o_valid and cannot be held off, so the
// receiver must take it then. The table lives in one memory with a single registered
// read port. Append and clear answer from idle; an access first searches from the
// front, then moves the entry forward past each entry just ahead of it whose count is
// strictly smaller and writes it back (a miss searches the whole table); a dump returns
// its results on consecutive cycles. Each result is registered and shows up in the
// cycle after the one that produced it, and a new transaction may be accepted in the
// cycle that the final result of the previous one is shown.
module frequency_ordered_list_unit #(
    parameter int DEPTH = fol_pkg::DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  fol_pkg::t_cmd    i_cmd,
    output logic             o_valid,
    output fol_pkg::t_result o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int PW = (LW > 4) ? LW : 4;
    localparam int EW = $bits(fol_pkg::t_entry);

    fol_pkg::t_state  r_state, n_state;
    logic [LW-1:0]    r_len, n_len;
    logic [AW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_pos, n_pos;
    logic [7:0]       r_key, n_key;
    logic [15:0]      r_cnt, n_cnt;
    logic             r_valid, n_valid;
    fol_pkg::t_result r_out, n_out;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    fol_pkg::t_entry  ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_rdata;
    fol_pkg::t_entry  rd;

    assign rd = fol_pkg::t_entry'(ram_rdata);

    fol_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fol_pkg::S_IDLE;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_valid <= n_valid;
        end
    end

    // Working registers of the current transaction.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_key <= n_key;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    // Next state, memory accesses and result.
    always_comb begin
        logic [PW-1:0] v_pos;
        logic [PW-1:0] v_idx;
        logic [PW-1:0] v_len;
        logic          v_last;

        n_state   = r_state;
        n_len     = r_len;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_key     = r_key;
        n_cnt     = r_cnt;
        n_valid   = 1'b0;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = '{key: r_key, count: r_cnt};
        ram_raddr = '0;

        v_pos  = PW'(r_pos);
        v_idx  = PW'(r_idx);
        v_len  = PW'(r_len);
        v_last = (LW'(r_idx) + LW'(1) == r_len) ||
                 (v_idx == PW'(fol_pkg::MAX_RESULTS - 1));

        case (r_state)
            fol_pkg::S_IDLE: begin
                if (start) begin
                    n_key = i_cmd.key;
                    n_idx = '0;
                    case (i_cmd.kind)
                        fol_pkg::KIND_APPEND: begin
                            n_valid = 1'b1;
                            if (r_len == LW'(DEPTH)) begin
                                n_out = '{status: fol_pkg::ST_FULL, out_key: i_cmd.key,
                                          out_count: '0, position: '0, last: 1'b1};
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_len);
                                ram_wdata = '{key: i_cmd.key, count: '0};
                                n_len     = r_len + LW'(1);
                                n_out     = '{status: fol_pkg::ST_OK, out_key: i_cmd.key,
                                              out_count: '0, position: v_len[3:0],
                                              last: 1'b1};
                            end
                        end
                        fol_pkg::KIND_ACCESS: begin
                            if (r_len == '0) begin
                                n_valid = 1'b1;
                                n_out   = '{status: fol_pkg::ST_NOT_FOUND,
                                            out_key: i_cmd.key, out_count: '0,
                                            position: '0, last: 1'b1};
                            end else begin
                                n_state = fol_pkg::S_SEARCH;
                            end
                        end
                        fol_pkg::KIND_DUMP: begin
                            if (r_len == '0) begin
                                n_valid = 1'b1;
                                n_out   = '{status: fol_pkg::ST_EMPTY, out_key: '0,
                                            out_count: '0, position: '0, last: 1'b1};
                            end else begin
                                n_state = fol_pkg::S_DUMP;
                            end
                        end
                        fol_pkg::KIND_CLEAR: begin
                            n_len   = '0;
                            n_valid = 1'b1;
                            n_out   = '{status: fol_pkg::ST_OK, out_key: '0,
                                        out_count: '0, position: '0, last: 1'b1};
                        end
                        default: begin
                            n_state = fol_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // Scan from the front; the read data belongs to entry r_idx.
            fol_pkg::S_SEARCH: begin
                if (rd.key == r_key) begin
                    n_cnt = (rd.count == '1) ? rd.count : rd.count + 16'd1;
                    n_pos = r_idx;
                    if (r_idx == '0) begin
                        n_state = fol_pkg::S_WRITE;
                    end else begin
                        ram_raddr = r_idx - AW'(1);
                        n_state   = fol_pkg::S_BUBBLE;
                    end
                end else if (LW'(r_idx) + LW'(1) == r_len) begin
                    n_valid = 1'b1;
                    n_out   = '{status: fol_pkg::ST_NOT_FOUND, out_key: r_key,
                                out_count: '0, position: '0, last: 1'b1};
                    n_state = fol_pkg::S_IDLE;
                end else begin
                    ram_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end

            // The read data is the entry just ahead of r_pos; shift it back while
            // its count is strictly smaller than the moving entry's count.
            fol_pkg::S_BUBBLE: begin
                if (r_cnt > rd.count) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos;
                    ram_wdata = rd;
                    n_pos     = r_pos - AW'(1);
                    if (r_pos == AW'(1)) begin
                        n_state = fol_pkg::S_WRITE;
                    end else begin
                        ram_raddr = r_pos - AW'(2);
                    end
                end else begin
                    ram_we  = 1'b1;
                    n_valid = 1'b1;
                    n_out   = '{status: fol_pkg::ST_OK, out_key: r_key, out_count: r_cnt,
                                position: v_pos[3:0], last: 1'b1};
                    n_state = fol_pkg::S_IDLE;
                end
            end

            // Store the accessed entry at its final place.
            fol_pkg::S_WRITE: begin
                ram_we  = 1'b1;
                n_valid = 1'b1;
                n_out   = '{status: fol_pkg::ST_OK, out_key: r_key, out_count: r_cnt,
                            position: v_pos[3:0], last: 1'b1};
                n_state = fol_pkg::S_IDLE;
            end

            // One entry per cycle; the read data belongs to entry r_idx.
            fol_pkg::S_DUMP: begin
                n_valid = 1'b1;
                n_out   = '{status: fol_pkg::ST_OK, out_key: rd.key, out_count: rd.count,
                            position: v_idx[3:0], last: v_last};
                if (v_last) begin
                    n_state = fol_pkg::S_IDLE;
                end else begin
                    ram_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end

            default: begin
                n_state = fol_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != fol_pkg::S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

[rtl/core/fol_checker.sv]
`include "assert_macros.svh"

module fol_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input fol_pkg::t_result o_result
);

    logic accept;

    assign accept = start && !busy;

    // An accepted transaction either keeps the block busy or answers at once.
    `ASSERT_NEXT(a_accept_acts, i_clk, i_rst_n, accept, busy || o_valid)

    // The final result of a transaction leaves the block ready for the next one.
    `ASSERT_IMPLY(a_last_idle, i_clk, i_rst_n, o_valid && o_result.last, !busy)

    // Dump results come on consecutive cycles until the final one.
    `ASSERT_NEXT(a_dump_burst, i_clk, i_rst_n, o_valid && !o_result.last, o_valid)

    // An empty-table report is always a single result.
    `ASSERT_IMPLY(a_empty_single, i_clk, i_rst_n,
        o_valid && (o_result.status == fol_pkg::ST_EMPTY), o_result.last)

    // Reset silences the result strobe and clears busy.
    `ASSERT_NEXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_valid && !busy)

endmodule

bind frequency_ordered_list_unit fol_checker u_fol_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
